/* rtl/sps_pkg.sv */
// Shared constants, types and helpers of the serial pattern test statistic unit.
package sps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int MAX_BITS    = 1048576;
   localparam int FRAC_BITS   = 16;

   localparam int CFG_W  = 5;
   localparam int BYTE_W = 8;
   localparam int VB_W   = 4;
   localparam int OUT_W  = 54;
   localparam int BITS_W = 21;
   localparam int STAT_W = 2;
   localparam int SUM_W  = 64;

   localparam logic [CFG_W-1:0]  CFG_RESET   = 5'd3;
   localparam logic [VB_W-1:0]   VB_MAX      = 4'd8;
   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_SHORT  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SATUR  = 2'd2;

   localparam logic [OUT_W-1:0] POS_LIMIT = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] NEG_LIMIT = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic start;
      logic negative;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                input logic [SUM_W-1:0] b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

endpackage

/* rtl/serial_pattern_test_statistic_unit.sv */
// Top level: bit sequencer, pattern count memories, statistic arithmetic sequencer.
// Usage:
//  Request channel req_*: one byte of sequence bits (MSB first) with the number
//  of leading valid bits; req_tlast marks the final byte of a run.
//  Response channel rsp_*: one result per run, after the last byte: del1_fx,
//  del2_fx (signed, FRAC_BITS fraction bits), bits_total and status.
//  csr_wen/csr_wdata write the pattern length; it is taken at a run's first byte.
//  A byte is taken in the idle state only, and the next one not before each of its bits
//  has passed the read-modify-write of the count memories (read state, then update state).
//  End of run: wrap steps over the first m-1 bits (or a pairwise compare pass for a run
//  shorter than m), scaling of the sums, two serial divisions, then a clearing pass
//  over the 2^m lowest addresses of the count memories.
//  After reset a clearing pass over all 2^MAX_PATTERN addresses runs with req_tready low.
//  The result sits in an output register; a new run may be fed while it waits,
//  but the next result is held back until the previous one is taken.
module serial_pattern_test_statistic_unit #(
   parameter int MAX_PATTERN = sps_pkg::MAX_PATTERN,
   parameter int MAX_BITS    = sps_pkg::MAX_BITS,
   parameter int FRAC_BITS   = sps_pkg::FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wen,
   input  logic [sps_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // data_byte[7:0], valid_bits[11:8]
   input  logic                        req_tlast,  // last
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [135:0]                rsp_tdata   // del1_fx, del2_fx, bits_total, status
);

   localparam int MP = MAX_PATTERN;
   localparam int PW = $clog2(MP + 1);
   localparam int IW = $clog2(MP);
   localparam int NW = $clog2(MAX_BITS + 1);
   localparam int SW = sps_pkg::SUM_W;
   localparam int OW = sps_pkg::OUT_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PUSH, ST_UPD, ST_SHORT, ST_SQ, ST_SCALE,
      ST_PREP, ST_DIFF, ST_DSTART, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [sps_pkg::CFG_W-1:0]  plen_ff, plen_in;
   logic [sps_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic [sps_pkg::VB_W-1:0]   vb_ff, vb_in;
   logic [sps_pkg::VB_W-1:0]   bidx_ff, bidx_in;
   logic                       last_ff, last_in;
   logic [PW-1:0]              m_ff, m_in;
   logic                       open_ff, open_in;
   logic [MP-1:0]              win_ff, win_in;
   logic [MP-1:0]              head_ff, head_in;
   logic [PW-1:0]              fill_ff, fill_in;
   logic [NW-1:0]              n_ff, n_in;
   logic                       ovf_ff, ovf_in;
   logic [SW-1:0]              sums_ff [3];
   logic [SW-1:0]              sums_in [3];
   logic [2:0]                 en_ff, en_in;
   logic [MP-1:0]              addr_ff, addr_in;
   logic                       wrap_ff, wrap_in;
   logic [IW-1:0]              j_ff, j_in;
   logic [IW-1:0]              si_ff, si_in, sj_ff, sj_in;
   logic [IW-1:0]              pi_ff, pi_in, pj_ff, pj_in;
   logic [IW-1:0]              t_ff, t_in;
   logic [PW-1:0]              f_ff, f_in;
   logic [1:0]                 k_ff, k_in;
   logic [PW-1:0]              sh_ff, sh_in;
   logic [SW-1:0]              sq_ff, sq_in;
   logic                       o_ff, o_in;
   logic [SW-1:0]              pos_ff, pos_in, neg_ff, neg_in, mag_ff, mag_in;
   logic                       negf_ff, negf_in;
   logic [OW-1:0]              del1_ff, del1_in, del2_ff, del2_in;
   logic [sps_pkg::STAT_W-1:0] status_ff, status_in;
   logic [MP-1:0]              clr_ff, clr_in, clr_end_ff, clr_end_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [135:0]               rsp_data_ff, rsp_data_in;

   // memory ports
   logic                       wr_en;
   logic [MP-1:0]              wr_addr;
   logic [MP-1:0]              rd_addr;
   logic [NW-1:0]              rd_data [3];
   logic [NW-1:0]              wr_data [3];
   logic [2:0]                 wr_en_k;

   sps_pkg::div_ctrl_type      div_ctrl;
   sps_pkg::div_stat_type      div_stat;
   logic [OW-1:0]              div_result;

   // helpers
   logic [PW-1:0]              len_k [3];
   logic [MP-1:0]              mask_k [3];
   logic                       bit_v;
   logic [MP-1:0]              win_new;
   logic [NW:0]                limit_v;
   logic [2:0]                 en_v;
   logic [IW-1:0]              n_s;
   logic                       mis;
   logic [PW-1:0]              f_now;
   logic [PW-1:0]              m_clamp;
   logic [sps_pkg::VB_W-1:0]   vb_clamp;
   logic [SW-1:0]              s_cur;
   logic [2*NW-1:0]            n_sq;

   function automatic logic [IW-1:0] step_ptr(input logic [IW-1:0] p,
                                              input logic [IW-1:0] lim);
      return (p == lim - IW'(1)) ? '0 : p + IW'(1);
   endfunction

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         len_k[k]  = m_ff - PW'(k);
         mask_k[k] = ~({MP{1'b1}} << len_k[k]);
      end
      n_s      = n_ff[IW-1:0];
      bit_v    = wrap_ff ? head_ff[j_ff] : byte_ff[sps_pkg::BYTE_W-1];
      win_new  = {win_ff[MP-2:0], bit_v};
      limit_v  = wrap_ff ? (NW+1)'(j_ff) + (NW+1)'(2) : {1'b0, n_ff} + (NW+1)'(1);
      for (int k = 0; k < 3; k++) begin
         en_v[k] = (m_ff > PW'(k)) && (limit_v >= (NW+1)'(len_k[k]));
      end
      mis   = head_ff[pi_ff] != head_ff[pj_ff];
      f_now = (mis && (f_ff == m_ff)) ? PW'(t_ff) : f_ff;
      m_clamp = (plen_ff == '0) ? PW'(1) :
                ((32'(plen_ff) > MP) ? PW'(MP) : PW'(plen_ff));
      vb_clamp = (req_tdata[11:8] > sps_pkg::VB_MAX) ? sps_pkg::VB_MAX : req_tdata[11:8];
      s_cur    = sums_ff[k_ff];
      n_sq     = n_ff * n_ff;
   end

   always_comb begin
      state_in     = state_ff;
      plen_in      = csr_wen ? csr_wdata : plen_ff;
      byte_in      = byte_ff;
      vb_in        = vb_ff;
      bidx_in      = bidx_ff;
      last_in      = last_ff;
      m_in         = m_ff;
      open_in      = open_ff;
      win_in       = win_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      sums_in      = sums_ff;
      en_in        = en_ff;
      addr_in      = addr_ff;
      wrap_in      = wrap_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      pi_in        = pi_ff;
      pj_in        = pj_ff;
      t_in         = t_ff;
      f_in         = f_ff;
      k_in         = k_ff;
      sh_in        = sh_ff;
      sq_in        = sq_ff;
      o_in         = o_ff;
      pos_in       = pos_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      negf_in      = negf_ff;
      del1_in      = del1_ff;
      del2_in      = del2_ff;
      status_in    = status_ff;
      clr_in       = clr_ff;
      clr_end_in   = clr_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = win_new;
      div_ctrl.start    = 1'b0;
      div_ctrl.negative = negf_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + MP'(1);
            if (clr_ff == clr_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               byte_in  = req_tdata[7:0];
               vb_in    = vb_clamp;
               bidx_in  = '0;
               last_in  = req_tlast;
               wrap_in  = 1'b0;
               state_in = ST_PUSH;
               if (!open_ff) begin
                  m_in    = m_clamp;
                  open_in = 1'b1;
               end
            end
         end
         ST_PUSH: begin
            if (wrap_ff) begin
               win_in  = win_new;
               en_in   = en_v;
               addr_in = win_new;
               if (en_v != '0) begin
                  state_in = ST_UPD;
               end else if (PW'(j_ff) == m_ff - PW'(2)) begin
                  state_in = ST_SQ;
               end else begin
                  j_in = j_ff + IW'(1);
               end
            end else if (bidx_ff == vb_ff) begin
               // end of byte
               if (!last_ff) begin
                  state_in = ST_IDLE;
               end else if (n_ff != '0 && n_ff >= NW'(m_ff)) begin
                  status_in = ovf_ff ? sps_pkg::STAT_SATUR : sps_pkg::STAT_OK;
                  if (m_ff >= PW'(2)) begin
                     wrap_in = 1'b1;
                     j_in    = '0;
                  end else begin
                     state_in = ST_SQ;
                  end
               end else begin
                  status_in = sps_pkg::STAT_SHORT;
                  for (int k = 0; k < 3; k++) sums_in[k] = '0;
                  si_in = '0;
                  sj_in = '0;
                  pi_in = '0;
                  pj_in = '0;
                  t_in  = '0;
                  f_in  = m_ff;
                  state_in = (n_ff != '0) ? ST_SHORT : ST_SQ;
               end
            end else begin
               bidx_in = bidx_ff + sps_pkg::VB_W'(1);
               byte_in = {byte_ff[sps_pkg::BYTE_W-2:0], 1'b0};
               if (n_ff >= NW'(MAX_BITS)) begin
                  ovf_in = 1'b1;
               end else begin
                  win_in = win_new;
                  if (fill_ff < PW'(MP)) begin
                     head_in[fill_ff[IW-1:0]] = bit_v;
                     fill_in = fill_ff + PW'(1);
                  end
                  n_in    = n_ff + NW'(1);
                  en_in   = en_v;
                  addr_in = win_new;
                  if (en_v != '0) state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            for (int k = 0; k < 3; k++) begin
               if (en_ff[k]) begin
                  sums_in[k] = sps_pkg::sat_add(sums_ff[k], {{(SW-NW-1){1'b0}}, rd_data[k], 1'b1});
               end
            end
            if (!wrap_ff) begin
               state_in = ST_PUSH;
            end else if (PW'(j_ff) == m_ff - PW'(2)) begin
               state_in = ST_SQ;
            end else begin
               j_in     = j_ff + IW'(1);
               state_in = ST_PUSH;
            end
         end
         ST_SHORT: begin
            if (PW'(t_ff) == m_ff - PW'(1)) begin
               for (int k = 0; k < 3; k++) begin
                  if (m_ff > PW'(k) && f_now >= len_k[k]) begin
                     sums_in[k] = sums_ff[k] + SW'(1);
                  end
               end
               t_in = '0;
               f_in = m_ff;
               if (sj_ff == n_s - IW'(1)) begin
                  sj_in = '0;
                  si_in = si_ff + IW'(1);
                  pi_in = si_ff + IW'(1);
                  pj_in = '0;
                  if (si_ff == n_s - IW'(1)) state_in = ST_SQ;
               end else begin
                  sj_in = sj_ff + IW'(1);
                  pi_in = si_ff;
                  pj_in = sj_ff + IW'(1);
               end
            end else begin
               t_in  = t_ff + IW'(1);
               f_in  = f_now;
               pi_in = step_ptr(pi_ff, n_s);
               pj_in = step_ptr(pj_ff, n_s);
            end
         end
         ST_SQ: begin
            sq_in    = SW'(n_sq);
            k_in     = '0;
            sh_in    = m_ff;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (!(m_ff > PW'(k_ff)) || n_ff == '0 || sh_ff == '0) begin
               if (!(m_ff > PW'(k_ff)) || n_ff == '0) begin
                  sums_in[k_ff] = '0;
               end else begin
                  sums_in[k_ff] = (s_cur > sq_ff) ? s_cur - sq_ff : '0;
               end
               k_in  = k_ff + 2'd1;
               sh_in = m_ff - PW'(k_ff) - PW'(1);
               if (k_ff == 2'd2) begin
                  o_in     = 1'b0;
                  state_in = ST_PREP;
               end
            end else begin
               sums_in[k_ff] = s_cur[SW-1] ? {SW{1'b1}} : {s_cur[SW-2:0], 1'b0};
               sh_in = sh_ff - PW'(1);
            end
         end
         ST_PREP: begin
            if (!o_ff) begin
               pos_in = sums_ff[0];
               neg_in = sums_ff[1];
            end else begin
               pos_in = sps_pkg::sat_add(sums_ff[0], sums_ff[2]);
               neg_in = sps_pkg::sat_add(sums_ff[1], sums_ff[1]);
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            negf_in  = neg_ff > pos_ff;
            mag_in   = (neg_ff > pos_ff) ? neg_ff - pos_ff : pos_ff - neg_ff;
            state_in = ST_DSTART;
         end
         ST_DSTART: begin
            if (n_ff == '0) begin
               if (!o_ff) begin
                  del1_in  = '0;
                  o_in     = 1'b1;
                  state_in = ST_PREP;
               end else begin
                  del2_in  = '0;
                  state_in = ST_OUT;
               end
            end else begin
               div_ctrl.start = 1'b1;
               state_in       = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (!o_ff) begin
                  del1_in  = div_result;
                  o_in     = 1'b1;
                  state_in = ST_PREP;
               end else begin
                  del2_in  = div_result;
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, status_ff, sps_pkg::BITS_W'(n_ff), del2_ff, del1_ff};
               clr_in       = '0;
               clr_end_in   = mask_k[0];
               win_in       = '0;
               head_in      = '0;
               fill_in      = '0;
               n_in         = '0;
               ovf_in       = 1'b0;
               open_in      = 1'b0;
               wrap_in      = 1'b0;
               for (int k = 0; k < 3; k++) sums_in[k] = '0;
               state_in     = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         plen_ff      <= sps_pkg::CFG_RESET;
         m_ff         <= PW'(3);
         open_ff      <= 1'b0;
         win_ff       <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         wrap_ff      <= 1'b0;
         for (int k = 0; k < 3; k++) sums_ff[k] <= '0;
         clr_ff       <= '0;
         clr_end_ff   <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         m_ff         <= m_in;
         open_ff      <= open_in;
         win_ff       <= win_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         wrap_ff      <= wrap_in;
         sums_ff      <= sums_in;
         clr_ff       <= clr_in;
         clr_end_ff   <= clr_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byte_ff     <= byte_in;
      vb_ff       <= vb_in;
      bidx_ff     <= bidx_in;
      last_ff     <= last_in;
      en_ff       <= en_in;
      addr_ff     <= addr_in;
      j_ff        <= j_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      pi_ff       <= pi_in;
      pj_ff       <= pj_in;
      t_ff        <= t_in;
      f_ff        <= f_in;
      k_ff        <= k_in;
      sh_ff       <= sh_in;
      sq_ff       <= sq_in;
      o_ff        <= o_in;
      pos_ff      <= pos_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      negf_ff     <= negf_in;
      del1_ff     <= del1_in;
      del2_ff     <= del2_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // memory write side: count update or clearing pass
   always_comb begin
      wr_en   = (state_ff == ST_CLEAR);
      wr_addr = wr_en ? clr_ff : addr_ff;
      for (int k = 0; k < 3; k++) begin
         wr_en_k[k] = wr_en || (state_ff == ST_UPD && en_ff[k]);
         wr_data[k] = wr_en ? '0 : rd_data[k] + NW'(1);
      end
   end

   sps_ram #(.WIDTH(NW), .DEPTH(1 << MP)) u_ram_full (
      .clock   (clock),
      .wr_en   (wr_en_k[0]),
      .wr_addr (wr_en ? wr_addr : (wr_addr & mask_k[0])),
      .wr_data (wr_data[0]),
      .rd_addr (rd_addr & mask_k[0]),
      .rd_data (rd_data[0])
   );

   sps_ram #(.WIDTH(NW), .DEPTH(1 << (MP - 1))) u_ram_less1 (
      .clock   (clock),
      .wr_en   (wr_en_k[1]),
      .wr_addr (wr_en ? wr_addr[MP-2:0] : (addr_ff[MP-2:0] & mask_k[1][MP-2:0])),
      .wr_data (wr_data[1]),
      .rd_addr (rd_addr[MP-2:0] & mask_k[1][MP-2:0]),
      .rd_data (rd_data[1])
   );

   sps_ram #(.WIDTH(NW), .DEPTH(1 << (MP - 2))) u_ram_less2 (
      .clock   (clock),
      .wr_en   (wr_en_k[2]),
      .wr_addr (wr_en ? wr_addr[MP-3:0] : (addr_ff[MP-3:0] & mask_k[2][MP-3:0])),
      .wr_data (wr_data[2]),
      .rd_addr (rd_addr[MP-3:0] & mask_k[2][MP-3:0]),
      .rd_data (rd_data[2])
   );

   sps_div #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .mag     (mag_ff),
      .divisor (n_ff),
      .stat    (div_stat),
      .result  (div_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_bits_cap: assert property (@(posedge clock) disable iff (reset)
      32'(n_ff) <= MAX_BITS)
      else $error("bit count beyond capacity");
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result loaded outside output state");
   a_upd_en: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> (en_ff != '0))
      else $error("count update without enabled store");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on idle divider");
`endif

endmodule

/* rtl/sps_ram.sv */
// Generic single write port, single registered read port RAM.
module sps_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/sps_div.sv */
// Bit-serial restoring divider: saturated fixed point quotient of magnitude by bit count.
module sps_div #(
   parameter int FRAC_BITS = sps_pkg::FRAC_BITS,
   parameter int NW        = 21
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sps_pkg::div_ctrl_type       ctrl,
   input  logic [sps_pkg::SUM_W-1:0]   mag,
   input  logic [NW-1:0]               divisor,
   output sps_pkg::div_stat_type       stat,
   output logic [sps_pkg::OUT_W-1:0]   result
);

   localparam int DW    = sps_pkg::SUM_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DW + 1);
   localparam int QW    = sps_pkg::OUT_W;

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [NW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [NW:0]      rem2;
   logic [NW:0]      diff;
   logic             ge;
   logic [QW-1:0]    limit;
   logic [QW-1:0]    mag_v;

   always_comb begin
      rem2 = {rem_ff, dvd_ff[DW-1]};
      diff = rem2 - {1'b0, divisor};
      ge   = (rem2 >= {1'b0, divisor});

      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (ctrl.start) begin
         dvd_in  = {mag, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         q_in    = '0;
         ovf_in  = 1'b0;
         neg_in  = ctrl.negative;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         rem_in = ge ? diff[NW-1:0] : rem2[NW-1:0];
         // a quotient bit pushed off the top means the result saturates
         ovf_in = ovf_ff | q_ff[QW-1];
         q_in   = {q_ff[QW-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      limit = neg_ff ? sps_pkg::NEG_LIMIT : sps_pkg::POS_LIMIT;
      mag_v = (ovf_ff || (q_ff > limit)) ? limit : q_ff;
      result = neg_ff ? (QW'(0) - mag_v) : mag_v;
      stat.busy = busy_ff;
      stat.done = done_ff;
   end

`ifndef SYNTHESIS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> busy_ff)
      else $error("divider not busy after start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("divider busy with empty count");
`endif

endmodule

/* dv/tb_serial_pattern_test_statistic_unit.sv */
// Testbench for the serial pattern test statistic unit: random runs checked against a predictor.
`timescale 1ns / 100ps

module tb_serial_pattern_test_statistic_unit;

   typedef struct {
      logic [sps_pkg::OUT_W-1:0]  del1;
      logic [sps_pkg::OUT_W-1:0]  del2;
      logic [sps_pkg::BITS_W-1:0] bits;
      logic [sps_pkg::STAT_W-1:0] status;
   } run_result_type;

   class pattern_scoreboard;
      int unsigned       cnt_m[1 << sps_pkg::MAX_PATTERN];
      int unsigned       cnt_m1[1 << (sps_pkg::MAX_PATTERN - 1)];
      int unsigned       cnt_m2[1 << (sps_pkg::MAX_PATTERN - 2)];
      longint unsigned   sq_sum[3];
      int unsigned       win, head, head_n, nbits, len_cfg, len_run;
      bit                ovf, open;
      run_result_type    expected_runs[$];
      int                errors;

      function void init();
         foreach (cnt_m[i]) cnt_m[i] = 0;
         foreach (cnt_m1[i]) cnt_m1[i] = 0;
         foreach (cnt_m2[i]) cnt_m2[i] = 0;
         foreach (sq_sum[i]) sq_sum[i] = 0;
         win = 0; head = 0; head_n = 0; nbits = 0;
         ovf = 0; open = 0;
         len_cfg = sps_pkg::CFG_RESET;
         len_run = sps_pkg::CFG_RESET;
         errors = 0;
      endfunction

      function void set_len(logic [sps_pkg::CFG_W-1:0] v);
         len_cfg = v;
      endfunction

      function longint unsigned sadd(longint unsigned a, longint unsigned b);
         return (a > 64'hFFFF_FFFF_FFFF_FFFF - b) ? 64'hFFFF_FFFF_FFFF_FFFF : a + b;
      endfunction

      function void tally(int unsigned lp);
         int len;
         int unsigned idx, c;
         for (int k = 0; k < 3; k++) begin
            len = int'(len_run) - k;
            if (len < 1 || lp < len) continue;
            idx = win & ((1 << len) - 1);
            c = (k == 0) ? cnt_m[idx] : (k == 1) ? cnt_m1[idx] : cnt_m2[idx];
            sq_sum[k] = sadd(sq_sum[k], 2 * longint'(c) + 1);
            if (k == 0) cnt_m[idx]++;
            else if (k == 1) cnt_m1[idx]++;
            else cnt_m2[idx]++;
         end
      endfunction

      function void add_bit(bit b);
         if (nbits >= sps_pkg::MAX_BITS) begin
            ovf = 1;
            return;
         end
         win = ((win << 1) | b) & 32'hFFFF;
         if (head_n < sps_pkg::MAX_PATTERN) begin
            head = (head << 1) | b;
            head_n++;
         end
         nbits++;
         tally(nbits);
      endfunction

      function bit head_at(int unsigned j);
         if (j >= head_n) return 0;
         return (head >> (head_n - 1 - j)) & 1;
      endfunction

      // sequence shorter than the pattern: windows wrap several times
      function longint unsigned wrap_sum(int unsigned n, int unsigned len);
         int unsigned keys[sps_pkg::MAX_PATTERN];
         int unsigned key;
         longint unsigned s;
         s = 0;
         for (int unsigned i = 0; i < n && i < sps_pkg::MAX_PATTERN; i++) begin
            key = 0;
            for (int unsigned j = 0; j < len; j++) key = (key << 1) | head_at((i + j) % n);
            keys[i] = key;
         end
         for (int unsigned i = 0; i < n && i < sps_pkg::MAX_PATTERN; i++)
            for (int unsigned j = 0; j < n && j < sps_pkg::MAX_PATTERN; j++)
               if (keys[i] == keys[j]) s++;
         return s;
      endfunction

      function logic [sps_pkg::OUT_W-1:0] fixq(longint unsigned pos, longint unsigned neg,
                                               int unsigned n);
         bit negv;
         longint unsigned mag, lim, q, r, v;
         if (n == 0) return '0;
         negv = neg > pos;
         mag = negv ? neg - pos : pos - neg;
         lim = negv ? longint'(sps_pkg::NEG_LIMIT) : longint'(sps_pkg::POS_LIMIT);
         q = mag / n;
         r = mag % n;
         if (q > (lim >> sps_pkg::FRAC_BITS)) v = lim;
         else begin
            v = (q << sps_pkg::FRAC_BITS) + ((r << sps_pkg::FRAC_BITS) / n);
            if (v > lim) v = lim;
         end
         return negv ? sps_pkg::OUT_W'(-v) : sps_pkg::OUT_W'(v);
      endfunction

      function run_result_type close_run();
         run_result_type res;
         longint unsigned p[3];
         longint unsigned s, nsq;
         int len;
         int unsigned n;
         n = nbits;
         p[0] = 0; p[1] = 0; p[2] = 0;
         if (n >= len_run && n > 0) begin
            for (int unsigned j = 0; j + 1 < len_run; j++) begin
               win = ((win << 1) | head_at(j)) & 32'hFFFF;
               tally(j + 2);
            end
            res.status = ovf ? sps_pkg::STAT_SATUR : sps_pkg::STAT_OK;
         end else res.status = sps_pkg::STAT_SHORT;
         for (int k = 0; k < 3; k++) begin
            len = int'(len_run) - k;
            if (len < 1 || n == 0) continue;
            s = (n < len_run) ? wrap_sum(n, len) : sq_sum[k];
            nsq = longint'(n) * longint'(n);
            s = (s > (64'hFFFF_FFFF_FFFF_FFFF >> len)) ? 64'hFFFF_FFFF_FFFF_FFFF : s << len;
            p[k] = (s > nsq) ? s - nsq : 0;
         end
         res.del1 = fixq(p[0], p[1], n);
         res.del2 = fixq(sadd(p[0], p[2]), sadd(p[1], p[1]), n);
         res.bits = sps_pkg::BITS_W'(n);
         for (int k = 0; k < 3; k++) begin
            len = int'(len_run) - k;
            if (len < 1) continue;
            for (int i = 0; i < (1 << len); i++) begin
               if (k == 0) cnt_m[i] = 0;
               else if (k == 1) cnt_m1[i] = 0;
               else cnt_m2[i] = 0;
            end
            sq_sum[k] = 0;
         end
         win = 0; head = 0; head_n = 0; nbits = 0;
         ovf = 0; open = 0;
         return res;
      endfunction

      function void note_req(logic [7:0] b, logic [3:0] vb, logic last);
         int unsigned nv;
         nv = (vb > 8) ? 8 : vb;
         if (!open) begin
            len_run = (len_cfg < 1) ? 1 :
                      (len_cfg > sps_pkg::MAX_PATTERN) ? sps_pkg::MAX_PATTERN : len_cfg;
            open = 1;
         end
         for (int unsigned i = 0; i < nv; i++) add_bit(b[7 - i]);
         if (last) expected_runs.push_back(close_run());
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         errors++;
         $display("mismatch %s: got %h want %h", what, got, want);
      endtask

      task check(logic [135:0] d);
         run_result_type e;
         if (expected_runs.size() == 0) begin
            report("unexpected result", d[63:0], 0);
            return;
         end
         e = expected_runs.pop_front();
         if (d[53:0] !== e.del1) report("del1_fx", d[53:0], e.del1);
         if (d[107:54] !== e.del2) report("del2_fx", d[107:54], e.del2);
         if (d[128:108] !== e.bits) report("bits_total", d[128:108], e.bits);
         if (d[130:129] !== e.status) report("status", d[130:129], e.status);
      endtask
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      csr_wen = 0;
   logic [sps_pkg::CFG_W-1:0] csr_wdata = '0;
   logic                      req_tvalid = 0;
   logic                      req_tready;
   logic [15:0]               req_tdata = '0;  // data_byte[7:0], valid_bits[11:8]
   logic                      req_tlast = 0;   // last
   logic                      rsp_tvalid;
   logic                      rsp_tready = 0;
   logic [135:0]              rsp_tdata;       // del1_fx, del2_fx, bits_total, status

   pattern_scoreboard sb;
   bit                quiet = 0;
   bit                hold_req = 0;

   serial_pattern_test_statistic_unit dut (
      .clock(clock), .reset(reset),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   initial begin
      #400_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stall bursts, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata);
         if (hold_req) begin
            hold_req = 0;
            rsp_tready <= 0;
            repeat (4000) @(posedge clock);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 13);
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   task send_req(logic [7:0] b, logic [3:0] vb, logic last);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {4'b0, vb, b};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_req(b, vb, last);
   endtask

   // wait out all results plus the count memory clearing pass
   task settle();
      req_tvalid <= 0;
      while (sb.expected_runs.size() != 0) @(posedge clock);
      repeat ((1 << sps_pkg::MAX_PATTERN) + 200) @(posedge clock);
   endtask

   task write_len(logic [sps_pkg::CFG_W-1:0] v);
      csr_wen <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 0;
      sb.set_len(v);
   endtask

   function logic [3:0] pick_vb();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 4'd8;
      if (r < 8) return 4'($urandom_range(1, 7));
      if (r == 8) return 4'($urandom_range(9, 15));
      return 4'd0;
   endfunction

   task random_runs(int nbytes);
      int sent, len;
      sent = 0;
      while (sent < nbytes) begin
         len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 30);
         for (int i = 0; i < len; i++)
            send_req(8'($urandom), pick_vb(), i == len - 1);
         sent += len;
      end
   endtask

   task directed();
      send_req(8'h00, 4'd8, 0);
      send_req(8'hFF, 4'd8, 1);
      send_req(8'hA5, 4'd0, 1);        // empty run
      send_req(8'h80, 4'd1, 1);        // one bit: shorter than any pattern longer than one
      send_req(8'h5A, 4'd15, 1);       // oversize valid count
      send_req(8'hC3, 4'd4, 0);
      send_req(8'h3C, 4'd9, 0);
      send_req(8'hFF, 4'd2, 1);
   endtask

   initial begin
      logic [sps_pkg::CFG_W-1:0] lens[8];
      lens = '{5'd16, 5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd5, 5'd3};
      sb = new();
      sb.init();
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed();
      random_runs(200);
      foreach (lens[p]) begin
         settle();
         write_len(lens[p]);
         directed();
         if (p == 1) hold_req = 1;
         if (p == 7) quiet = 1;
         random_runs(p == 7 ? 150 : 190);
      end
      req_tvalid <= 0;
      while (sb.expected_runs.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
